/* rtl/core/dthr_pkg.sv */
// ----------------------------------------------------------------------------
// dthr_pkg: shared types and constants for the double to hex-real converter
// Field widths, bit positions and special encodings of both formats.
// ----------------------------------------------------------------------------
package dthr_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned BexpW  = 11;
  localparam int unsigned FracW  = 52;
  localparam int unsigned HexExpW = 7;
  localparam int unsigned MantW  = 56;

  localparam logic [BexpW-1:0] BexpAllOnes = 11'h7FF;
  // binary64 pattern of the double nearest 1e-77 (sign cleared)
  localparam logic [WordW-2:0] TinyMag     = 63'h2FF2_86D8_0EC1_90DC;
  localparam logic [HexExpW-1:0] ZeroExpField = 7'd64;
  // field = ((bexp+1)>>2) - 191
  localparam logic [BexpW-2:0] FieldBias   = 10'd191;

  typedef struct packed {
    logic               sign;
    logic               special;  // infinity or NaN
    logic               tiny;
    logic [BexpW-1:0]   bexp;
    logic [FracW-1:0]   frac;
  } dthr_s1_t;

  typedef struct packed {
    logic               sign;
    logic               force_zero;   // result word cleared, flag set
    logic               tiny;
    logic [HexExpW-1:0] field;
    logic [1:0]         shamt;
    logic [FracW-1:0]   frac;
  } dthr_s2_t;

endpackage

/* rtl/core/double_to_hex_real8.sv */
// ----------------------------------------------------------------------------
// double_to_hex_real8: IEEE-754 binary64 to excess-64 base-16 long real
// Three-stage pipeline: classify, exponent rebias, mantissa align.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel ieee_bits_i with in_valid_i/in_ready_o; output channel
//   hex_real_o/out_of_range_o with out_valid_o/out_ready_i. A transaction
//   happens when valid and ready are both high at a rising edge.
//   Results pass the stage 1, stage 2 and output registers. One item is
//   accepted per cycle while out_ready_i is high; each stage advances
//   when empty or when its successor advances: a full pipeline streams.
//   When the receiver stalls, the output register holds its result and
//   the stages behind it fill up; in_ready_o drops once all three hold
//   items. Nothing is lost or repeated.
//   Reset (rst_ni low, asynchronous) clears all stage valid bits; data
//   registers are not reset. Exactly one result per input, in order.
//   Infinity, NaN and exponent overflow give a zero word with the flag
//   set; zeros, denormals and magnitudes below 1e-77 give mantissa 0,
//   exponent field 64, sign kept.
// ----------------------------------------------------------------------------
module double_to_hex_real8
  import dthr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] ieee_bits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] hex_real_o,
  output logic             out_of_range_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  dthr_s1_t s1_d, s1_q;
  dthr_s2_t s2_d, s2_q;
  logic [WordW-1:0] res_d, res_q;
  logic oor_d, oor_q;

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  // stage 1: classify
  always_comb begin
    s1_d.sign    = ieee_bits_i[WordW-1];
    s1_d.bexp    = ieee_bits_i[WordW-2 -: BexpW];
    s1_d.frac    = ieee_bits_i[FracW-1:0];
    s1_d.special = (s1_d.bexp == BexpAllOnes);
    s1_d.tiny    = (ieee_bits_i[WordW-2:0] < TinyMag);
  end

  // stage 2: exponent field
  logic [BexpW-1:0] bexp_p1;
  logic [BexpW-2:0] quad;
  always_comb begin
    bexp_p1 = s1_q.bexp + 11'd1;
    quad    = {1'b0, bexp_p1[BexpW-1:2]};
    s2_d.sign       = s1_q.sign;
    s2_d.tiny       = s1_q.tiny;
    s2_d.frac       = s1_q.frac;
    s2_d.shamt      = bexp_p1[1:0];
    s2_d.field      = HexExpW'(quad - FieldBias);
    // bexp=2047 wraps bexp_p1 to 0, but special is flagged separately
    s2_d.force_zero = s1_q.special ||
                      (!s1_q.tiny && ((quad < FieldBias) ||
                                      (quad > FieldBias + 10'd127)));
  end

  // stage 3: mantissa align and pack
  logic [MantW-1:0] mant;
  always_comb begin
    mant = MantW'({1'b1, s2_q.frac}) << s2_q.shamt;
    oor_d = s2_q.force_zero;
    if (s2_q.force_zero) begin
      res_d = '0;
    end else if (s2_q.tiny) begin
      res_d = {s2_q.sign, ZeroExpField, {MantW{1'b0}}};
    end else begin
      res_d = {s2_q.sign, s2_q.field, mant};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
    if (adv3 && v2_q) begin
      res_q <= res_d;
      oor_q <= oor_d;
    end
  end

  assign out_valid_o    = v3_q;
  assign hex_real_o     = res_q;
  assign out_of_range_o = oor_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hex_real_o)))
    else $error("result changed under stall");

  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_ready_i) |-> !in_ready_o)
    else $error("accepted while full");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (hex_real_o == '0))
    else $error("flagged result not zero");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !v1_q && !v2_q && !v3_q && out_ready_i)
      |=> ##2 out_valid_o)
    else $error("latency mismatch");

endmodule

/* tb/double_to_hex_real8_checker.sv */
// ----------------------------------------------------------------------------
// double_to_hex_real8_checker: result checker for the hex-real converter
// Watches both channels, computes the expected long real for every input
// transaction and compares each output transaction against it in order.
// ----------------------------------------------------------------------------
module double_to_hex_real8_checker
  import dthr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [WordW-1:0] ieee_bits_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [WordW-1:0] hex_real_i,
  input  logic             out_of_range_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             oor;
  } hex_result_t;

  hex_result_t expected_q[$];
  int          fail_count;
  int          pending;

  function automatic hex_result_t convert_double(logic [WordW-1:0] x);
    hex_result_t   r;
    logic [10:0]   bexp;
    int            field;
    logic [55:0]   mant;
    bexp = x[62:52];
    r.word = '0;
    r.oor  = 1'b0;
    if (bexp == 11'h7FF) begin
      r.oor = 1'b1;
    end else if (x[62:0] < TinyMag) begin
      r.word = {x[63], 7'd64, 56'd0};
    end else begin
      field = int'((bexp + 12'd1) >> 2) - 191;
      if (field < 0 || field > 127) begin
        r.oor = 1'b1;
      end else begin
        mant = 56'({1'b1, x[51:0]}) << ((bexp + 11'd1) & 11'd3);
        r.word = {x[63], field[6:0], mant};
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    hex_result_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) expected_q.push_back(convert_double(ieee_bits_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: hex_real=%h oor=%b", hex_real_i, out_of_range_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.word !== hex_real_i || exp_r.oor !== out_of_range_i) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected hex_real=%h oor=%b, got hex_real=%h oor=%b",
                       exp_r.word, exp_r.oor, hex_real_i, out_of_range_i);
          end
        end
      end
      pending = expected_q.size();
    end
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end
  assign fail_count_o = fail_count;
  assign pending_o    = pending;

endmodule

/* tb/double_to_hex_real8_test.sv */
// ----------------------------------------------------------------------------
// double_to_hex_real8_test: testbench for the double to hex-real converter
// Sends directed corner values then random doubles with random gaps and
// output stalls (one stretch has neither); the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module double_to_hex_real8_test;
  import dthr_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [WordW-1:0] ieee_bits_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] hex_real_o;
  logic             out_of_range_o;
  int               fail_count;
  int               pending;
  int               ready_wait = 0;
  bit               stall_free;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  double_to_hex_real8 DUT (.*);

  double_to_hex_real8_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .ieee_bits_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hex_real_i(hex_real_o),
    .out_of_range_i(out_of_range_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // valid stays up between back-to-back transactions; it drops only for a gap
  task automatic send_double(logic [WordW-1:0] x, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      if (in_valid_i) in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ieee_bits_i <= x;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // random double; biased exponents near the tiny and overflow boundaries
  function automatic logic [WordW-1:0] random_double();
    logic [10:0] bexp;
    logic [51:0] frac;
    frac = 52'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: bexp = 11'($urandom_range(0, 1023 - 260));
      1: bexp = 11'($urandom_range(1023 - 260, 1023 - 250));
      2: bexp = 11'($urandom_range(1023 + 248, 1023 + 256));
      3: bexp = 11'($urandom_range(0, 2047));
      4: bexp = ($urandom_range(0, 3) == 0) ? 11'h7FF : 11'd0;
      default: bexp = 11'($urandom_range(1023 - 40, 1023 + 40));
    endcase
    return {1'($urandom), bexp, frac};
  endfunction

  // receiver: after each transaction, hold ready low for a randomly drawn wait unless stall_free is set
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) ready_wait = $urandom_range(0, 11);
  end

  always @(negedge clk_i) begin
    if (stall_free) out_ready_i <= 1'b1;
    else if (ready_wait > 0) begin
      out_ready_i <= 1'b0;
      ready_wait--;
    end else out_ready_i <= 1'b1;
  end

  initial begin
    logic [WordW-1:0] corners[$];
    corners = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                64'h800F_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                64'hFFFF_FFFF_FFFF_FFFF, {1'b0, TinyMag}, {1'b1, TinyMag - 63'd1},
                {1'b0, TinyMag + 63'd1}, 64'h3FF0_0000_0000_0000,
                64'hBFF0_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF,
                64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000,
                64'h4020_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                64'h42F0_0000_0000_0000, 64'h42EF_FFFF_FFFF_FFFF,
                64'hC2F0_0000_0000_0000, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA};
    stall_free = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (corners[i]) send_double(corners[i], 1'b0);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    // hold off until the pipeline has drained
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < 530; i++) begin
      stall_free = (i >= 200 && i < 260);
      send_double(random_double(), stall_free);
    end
    in_valid_i <= 1'b0;
    stall_free = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
